@@ sv/dcg_pkg.sv @@
// Package for the dedispersion chirp generator: widths, register codes,
// control struct, limb multiplier helpers and the CORDIC arctangent table.
// Used by every module.
`default_nettype none
package dcg_pkg;

  localparam int LOG2_POINTS = 12;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DM = 2'd0;
  localparam logic [1:0] REG_F0 = 2'd1;
  localparam logic [1:0] REG_BW = 2'd2;

  localparam int DM_W = 20;
  localparam int F0_W = 24;
  localparam int BW_W = 24;

  // Numerator dm * mag^2 * bw^2 * 5^15, the power of five taken as 5^8 * 5^7
  localparam int M2_W  = 2 * LOG2_POINTS;
  localparam int N1_W  = DM_W + M2_W;
  localparam int N2_W  = N1_W + BW_W;
  localparam int N3_W  = N2_W + BW_W;
  localparam int N4A_W = N3_W + 19;
  localparam int NUM_W = N3_W + 35;
  localparam logic [23:0] FIVE_POW8 = 24'd390625;
  localparam logic [23:0] FIVE_POW7 = 24'd78125;

  // Denominator 241 * f0^2 * (f0*N + offset*bw)
  localparam int S_W   = F0_W + LOG2_POINTS + 2;
  localparam int D1_W  = S_W - 1 + 8;
  localparam int D2_W  = D1_W + F0_W;
  localparam int DEN_W = D2_W + F0_W;
  localparam logic [7:0] DEN_SCALE = 8'd241;

  // Dividend is the numerator followed by the binary fraction bits
  localparam int FRAC_W = 37 - LOG2_POINTS;
  localparam int X_W    = NUM_W + FRAC_W;

  // Wide products: 24-bit limbs multiplied in one stage, summed in the next
  localparam int LIMB_W       = 24;
  localparam int LIMBS        = 5;
  localparam int WIDE_W       = LIMB_W * LIMBS;
  localparam int PROD_W       = WIDE_W + LIMB_W;
  localparam int ODD_W        = PROD_W - 2 * LIMB_W;
  localparam int FRONT_STAGES = 10;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 16;
  localparam int CX_W = 34;
  localparam int CZ_W = 33;
  localparam logic signed [CX_W-1:0] CORDIC_START = 34'sd652032874;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef struct packed {
    logic valid;
    logic bad;
  } ctl_t;

  // Even limb products never overlap, so they sit side by side
  function automatic logic [PROD_W-1:0] limb_even(input logic [WIDE_W-1:0] a,
                                                  input logic [LIMB_W-1:0] b);
    logic [PROD_W-1:0] r;
    r = '0;
    for (int j = 0; j < LIMBS; j += 2) begin
      r[j*LIMB_W +: 2*LIMB_W] = (2*LIMB_W)'(a[j*LIMB_W +: LIMB_W]) * (2*LIMB_W)'(b);
    end
    return r;
  endfunction

  // Odd limb products, one limb below their true position
  function automatic logic [ODD_W-1:0] limb_odd(input logic [WIDE_W-1:0] a,
                                                input logic [LIMB_W-1:0] b);
    logic [ODD_W-1:0] r;
    r = '0;
    for (int j = 1; j < LIMBS; j += 2) begin
      r[(j-1)*LIMB_W +: 2*LIMB_W] = (2*LIMB_W)'(a[j*LIMB_W +: LIMB_W]) * (2*LIMB_W)'(b);
    end
    return r;
  endfunction

  // Combine the two partial rows into the full product
  function automatic logic [PROD_W-1:0] limb_sum(input logic [PROD_W-1:0] ev,
                                                 input logic [ODD_W-1:0] od);
    return ev + PROD_W'({od, {LIMB_W{1'b0}}});
  endfunction

endpackage
`default_nettype wire

@@ sv/dedispersion_chirp_generator.sv @@
// Coherent dedispersion chirp: bin index in, cos/sin of the chirp phase out.
// The result passes through the limb multiplier stages, the row of one-bit
// division cells and the CORDIC cells, and then the output register.
// One item per cycle: busy never rises, done pulses once per item; the receiver cannot stall.
// Synchronous reset clears the valid marks and loads the register defaults.
// Depends on dcg_pkg, dcg_div_cell and dcg_cordic_cell.
`default_nettype none
module dedispersion_chirp_generator import dcg_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [23:0]        cfg_data,
  input  wire                start,
  output logic               busy,
  input  wire  [11:0]        bin_index,
  output logic               done,
  output logic signed [15:0] cos_part,
  output logic signed [15:0] sin_part,
  output logic               bad_frequency
);

  logic [DM_W-1:0] dispersion_measure;
  logic [F0_W-1:0] center_freq_khz;
  logic [BW_W-1:0] bandwidth_khz;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dispersion_measure <= '0;
      center_freq_khz    <= 24'd1000000;
      bandwidth_khz      <= 24'd100000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DM:  dispersion_measure <= cfg_data[DM_W-1:0];
        REG_F0:  center_freq_khz    <= cfg_data[F0_W-1:0];
        REG_BW:  bandwidth_khz      <= cfg_data[BW_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Wrap the bin into a signed offset
  logic [LOG2_POINTS-1:0] k;
  generate
    if (LOG2_POINTS <= 12) begin : g_narrow
      assign k = bin_index[LOG2_POINTS-1:0];
    end else begin : g_wide
      assign k = {{(LOG2_POINTS-12){1'b0}}, bin_index};
    end
  endgenerate

  logic [LOG2_POINTS-1:0] mag;
  logic signed [S_W-1:0]  prod_ob;
  logic signed [S_W-1:0]  sum;
  always_comb begin
    mag     = k[LOG2_POINTS-1] ? (~k + 1'b1) : k;
    prod_ob = S_W'($signed(k)) * S_W'($signed({1'b0, bandwidth_khz}));
    sum     = $signed({2'b00, center_freq_khz, {LOG2_POINTS{1'b0}}}) + prod_ob;
  end

  // Front multiplier pipeline
  ctl_t                  ctl_pipe [FRONT_STAGES];
  logic [M2_W-1:0]       m2;
  logic signed [S_W-1:0] sum1;
  logic [N1_W-1:0]       n1;
  logic [D1_W-1:0]       d1;
  logic [PROD_W-1:0]     n2_ev, d2_ev, n3_ev, d3_ev, n4a_ev, n4_ev;
  logic [ODD_W-1:0]      n2_od, d2_od, n3_od, d3_od, n4a_od, n4_od;
  logic [N2_W-1:0]       n2;
  logic [D2_W-1:0]       d2;
  logic [N3_W-1:0]       n3;
  logic [DEN_W-1:0]      d3;
  logic [N4A_W-1:0]      n4a;
  logic [DEN_W-1:0]      d7, d8, d9;
  logic [NUM_W-1:0]      n4;
  logic [DEN_W-1:0]      d4;

  // Advance the valid and bad marks alongside the products
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRONT_STAGES; i++) begin
        ctl_pipe[i] <= '0;
      end
    end else begin
      ctl_pipe[0].valid <= start && !busy;
      ctl_pipe[0].bad   <= (center_freq_khz == '0) || sum[S_W-1] || (sum == '0);
      for (int i = 1; i < FRONT_STAGES; i++) begin
        ctl_pipe[i] <= ctl_pipe[i-1];
      end
    end
  end

  // Each wide product takes a limb stage and a summing stage
  always_ff @(posedge clk) begin
    m2     <= M2_W'(mag) * M2_W'(mag);
    sum1   <= sum;
    n1     <= N1_W'(dispersion_measure) * N1_W'(m2);
    d1     <= D1_W'(sum1[S_W-2:0]) * D1_W'(DEN_SCALE);
    n2_ev  <= limb_even(WIDE_W'(n1), bandwidth_khz);
    n2_od  <= limb_odd(WIDE_W'(n1), bandwidth_khz);
    d2_ev  <= limb_even(WIDE_W'(d1), center_freq_khz);
    d2_od  <= limb_odd(WIDE_W'(d1), center_freq_khz);
    n2     <= N2_W'(limb_sum(n2_ev, n2_od));
    d2     <= D2_W'(limb_sum(d2_ev, d2_od));
    n3_ev  <= limb_even(WIDE_W'(n2), bandwidth_khz);
    n3_od  <= limb_odd(WIDE_W'(n2), bandwidth_khz);
    d3_ev  <= limb_even(WIDE_W'(d2), center_freq_khz);
    d3_od  <= limb_odd(WIDE_W'(d2), center_freq_khz);
    n3     <= N3_W'(limb_sum(n3_ev, n3_od));
    d3     <= DEN_W'(limb_sum(d3_ev, d3_od));
    n4a_ev <= limb_even(WIDE_W'(n3), FIVE_POW8);
    n4a_od <= limb_odd(WIDE_W'(n3), FIVE_POW8);
    d7     <= d3;
    n4a    <= N4A_W'(limb_sum(n4a_ev, n4a_od));
    d8     <= d7;
    n4_ev  <= limb_even(WIDE_W'(n4a), FIVE_POW7);
    n4_od  <= limb_odd(WIDE_W'(n4a), FIVE_POW7);
    d9     <= d8;
    n4     <= NUM_W'(limb_sum(n4_ev, n4_od));
    d4     <= d9;
  end

  // Division row: one quotient bit per cell
  ctl_t             dv_ctl [X_W+1];
  logic [DEN_W-1:0] dv_rem [X_W+1];
  logic [DEN_W-1:0] dv_den [X_W+1];
  logic [X_W-1:0]   dv_x   [X_W+1];
  logic [31:0]      dv_q   [X_W+1];

  assign dv_ctl[0] = ctl_pipe[FRONT_STAGES-1];
  assign dv_rem[0] = '0;
  assign dv_den[0] = d4;
  assign dv_x[0]   = {n4, {FRAC_W{1'b0}}};
  assign dv_q[0]   = '0;

  genvar g;
  generate
    for (g = 0; g < X_W; g++) begin : g_div
      dcg_div_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl_in  (dv_ctl[g]),
        .rem_in  (dv_rem[g]),
        .den_in  (dv_den[g]),
        .x_in    (dv_x[g]),
        .q_in    (dv_q[g]),
        .ctl_out (dv_ctl[g+1]),
        .rem_out (dv_rem[g+1]),
        .den_out (dv_den[g+1]),
        .x_out   (dv_x[g+1]),
        .q_out   (dv_q[g+1])
      );
    end
  endgenerate

  // CORDIC row
  ctl_t                   cr_ctl  [CORDIC_STEPS+1];
  logic [1:0]             cr_quad [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] cr_x    [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] cr_y    [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0] cr_z    [CORDIC_STEPS+1];

  assign cr_ctl[0]  = dv_ctl[X_W];
  assign cr_quad[0] = dv_q[X_W][31:30];
  assign cr_x[0]    = CORDIC_START;
  assign cr_y[0]    = '0;
  assign cr_z[0]    = $signed({3'b000, dv_q[X_W][29:0]});

  generate
    for (g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      dcg_cordic_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (4'(g)),
        .atan     (ATAN_TURNS[g]),
        .ctl_in   (cr_ctl[g]),
        .quad_in  (cr_quad[g]),
        .x_in     (cr_x[g]),
        .y_in     (cr_y[g]),
        .z_in     (cr_z[g]),
        .ctl_out  (cr_ctl[g+1]),
        .quad_out (cr_quad[g+1]),
        .x_out    (cr_x[g+1]),
        .y_out    (cr_y[g+1]),
        .z_out    (cr_z[g+1])
      );
    end
  endgenerate

  // Round Q4.30 to Q1.15 and saturate
  function automatic logic signed [15:0] to_q15(input logic signed [CX_W-1:0] v);
    logic signed [CX_W:0] r;
    logic signed [CX_W:0] q;
    begin
      r = $signed({v[CX_W-1], v}) + $signed((CX_W+1)'(1 << 14));
      q = r >>> 15;
      if (q > $signed((CX_W+1)'(32767))) begin
        to_q15 = 16'sd32767;
      end else if (q < -$signed((CX_W+1)'(32767))) begin
        to_q15 = -16'sd32767;
      end else begin
        to_q15 = q[15:0];
      end
    end
  endfunction

  logic signed [15:0] c_val;
  logic signed [15:0] s_val;
  logic signed [15:0] cos_next;
  logic signed [15:0] sin_next;

  // Apply the quadrant, force 1+0j on a bad frequency
  always_comb begin
    c_val = to_q15(cr_x[CORDIC_STEPS]);
    s_val = to_q15(cr_y[CORDIC_STEPS]);
    case (cr_quad[CORDIC_STEPS])
      2'd0:    begin cos_next = c_val;  sin_next = s_val;  end
      2'd1:    begin cos_next = -s_val; sin_next = c_val;  end
      2'd2:    begin cos_next = -c_val; sin_next = -s_val; end
      default: begin cos_next = s_val;  sin_next = -c_val; end
    endcase
    if (cr_ctl[CORDIC_STEPS].bad) begin
      cos_next = 16'sd32767;
      sin_next = 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cr_ctl[CORDIC_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    cos_part      <= cos_next;
    sin_part      <= sin_next;
    bad_frequency <= cr_ctl[CORDIC_STEPS].bad;
  end

endmodule
`default_nettype wire

@@ sv/dcg_div_cell.sv @@
// One restoring-division cell: takes one dividend bit, yields one quotient bit.
// Depends on dcg_pkg.
`default_nettype none
module dcg_div_cell import dcg_pkg::*; (
  input  wire                    clk,
  input  wire                    rst,
  input  ctl_t                   ctl_in,
  input  wire  [DEN_W-1:0]       rem_in,
  input  wire  [DEN_W-1:0]       den_in,
  input  wire  [X_W-1:0]         x_in,
  input  wire  [31:0]            q_in,
  output ctl_t                   ctl_out,
  output logic [DEN_W-1:0]       rem_out,
  output logic [DEN_W-1:0]       den_out,
  output logic [X_W-1:0]         x_out,
  output logic [31:0]            q_out
);

  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;
  logic [DEN_W-1:0] rem_next;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    trial    = {rem_in, x_in[X_W-1]};
    fits     = trial >= {1'b0, den_in};
    diff     = trial - {1'b0, den_in};
    rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_out <= rem_next;
    den_out <= den_in;
    x_out   <= {x_in[X_W-2:0], 1'b0};
    q_out   <= {q_in[30:0], fits};
  end

endmodule
`default_nettype wire

@@ sv/dcg_cordic_cell.sv @@
// One CORDIC rotation step with its own register.
// Depends on dcg_pkg; shift and arctangent come in from the chain.
`default_nettype none
module dcg_cordic_cell import dcg_pkg::*; (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  [3:0]                 shift,
  input  wire  [31:0]                atan,
  input  ctl_t                       ctl_in,
  input  wire  [1:0]                 quad_in,
  input  wire  signed [CX_W-1:0]     x_in,
  input  wire  signed [CX_W-1:0]     y_in,
  input  wire  signed [CZ_W-1:0]     z_in,
  output ctl_t                       ctl_out,
  output logic [1:0]                 quad_out,
  output logic signed [CX_W-1:0]     x_out,
  output logic signed [CX_W-1:0]     y_out,
  output logic signed [CZ_W-1:0]     z_out
);

  logic signed [CX_W-1:0] dx;
  logic signed [CX_W-1:0] dy;
  logic signed [CZ_W-1:0] da;
  logic signed [CX_W-1:0] x_next;
  logic signed [CX_W-1:0] y_next;
  logic signed [CZ_W-1:0] z_next;

  // Rotate towards zero residual angle
  always_comb begin
    dx = y_in >>> shift;
    dy = x_in >>> shift;
    da = $signed({1'b0, atan});
    if (!z_in[CZ_W-1]) begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - da;
    end else begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + da;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    quad_out <= quad_in;
    x_out    <= x_next;
    y_out    <= y_next;
    z_out    <= z_next;
  end

endmodule
`default_nettype wire
